>>> rtl/core/sample_quantizer_bit_packer_assert.svh
// assertion helpers shared by the sample quantizer bit packer modules
`ifndef SAMPLE_QUANTIZER_BIT_PACKER_ASSERT_SVH
`define SAMPLE_QUANTIZER_BIT_PACKER_ASSERT_SVH

// condition must hold at every edge outside reset
`define SQBP_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define SQBP_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/core/sqbp_pkg.sv
package sqbp_pkg;

   localparam int SAMPLE_W = 32;
   localparam int CSR_W    = 24;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W   = SAMPLE_W + CSR_W + 1;

   // bits_mode codes
   localparam logic [2:0] MODE_ONE     = 3'd0;
   localparam logic [2:0] MODE_TWO     = 3'd1;
   localparam logic [2:0] MODE_FOUR    = 3'd2;
   localparam logic [2:0] MODE_EIGHT   = 3'd3;
   localparam logic [2:0] MODE_SIXTEEN = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BITS_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_48    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_16    = 2'd3;

   // reset values
   localparam logic [2:0]       RST_BITS_MODE = MODE_TWO;
   localparam logic [CSR_W-1:0] RST_THRESHOLD = 24'd62915;
   localparam logic [CSR_W-1:0] RST_GAIN_48   = 24'd195278;
   localparam logic [CSR_W-1:0] RST_GAIN_16   = 24'd6553600;

   // wide code offsets and ceilings
   localparam logic [16:0] OFFSET_FOUR    = 17'd8;
   localparam logic [16:0] OFFSET_EIGHT   = 17'd128;
   localparam logic [16:0] OFFSET_SIXTEEN = 17'd32768;
   localparam logic [16:0] MAX_FOUR       = 17'd15;
   localparam logic [16:0] MAX_EIGHT      = 17'd255;
   localparam logic [16:0] MAX_SIXTEEN    = 17'd65535;

   typedef struct packed {
      logic [7:0] byte_lo;
      logic [7:0] byte_hi;
      logic       two_bytes;
      logic       frame_end;
   } sqbp_entry_type;

   typedef struct packed {
      logic full;
      logic near_full;
      logic empty;
   } sqbp_qstat_type;

endpackage

>>> rtl/core/sqbp_front.sv
module sqbp_front import sqbp_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic signed [SAMPLE_W-1:0]  req_sample,
   input  logic                        req_end_of_frame,
   input  logic                        csr_write_enable,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_W-1:0]            csr_write_data,
   input  sqbp_qstat_type              qstat,
   output logic                        push,
   output sqbp_entry_type              push_entry
);

   logic [2:0]       mode_ff;
   logic [CSR_W-1:0] thresh_ff;
   logic [CSR_W-1:0] gain48_ff;
   logic [CSR_W-1:0] gain16_ff;

   logic [7:0] acc_ff, acc_in;
   logic [2:0] pos_ff, pos_in;

   logic                     s1_valid_ff;
   logic signed [PROD_W-1:0] s1_product_ff;
   logic [1:0]               s1_code2_ff;
   logic                     s1_sign_ff;
   logic                     s1_eof_ff;

   logic                     accept;
   logic [CSR_W-1:0]         gain_sel;
   logic signed [PROD_W-1:0] product_c;
   logic signed [32:0]       samp_ext;
   logic signed [32:0]       thr_ext;
   logic [1:0]               code2_c;

   logic signed [24:0] floor_q;
   logic signed [25:0] offset_sum;
   logic [16:0]        offset_sel;
   logic [16:0]        max_sel;
   logic [15:0]        wide_code;
   logic [3:0]         narrow_code;
   logic [3:0]         width_w;
   logic [11:0]        shifted;
   logic [7:0]         acc_or;
   logic [3:0]         pos_sum;
   logic               emit;
   sqbp_entry_type     entry_c;

   assign req_full = qstat.full || (s1_valid_ff && qstat.near_full);
   assign accept   = req_push && !req_full;

   // multiply on entry, the product is registered before any use
   assign gain_sel  = (mode_ff == MODE_SIXTEEN) ? gain16_ff : gain48_ff;
   assign product_c = req_sample * $signed({1'b0, gain_sel});

   assign samp_ext = {req_sample[SAMPLE_W-1], req_sample};
   assign thr_ext  = $signed({9'b0, thresh_ff});

   always_comb begin
      if (samp_ext < -thr_ext) begin
         code2_c = 2'd0;
      end else if (req_sample[SAMPLE_W-1]) begin
         code2_c = 2'd1;
      end else if (samp_ext < thr_ext) begin
         code2_c = 2'd2;
      end else begin
         code2_c = 2'd3;
      end
   end

   // arithmetic shift of the product is floor toward minus infinity
   assign floor_q = s1_product_ff[PROD_W-1:32];

   always_comb begin
      unique case (mode_ff) inside
         MODE_EIGHT: begin
            offset_sel = OFFSET_EIGHT;
            max_sel    = MAX_EIGHT;
         end
         MODE_SIXTEEN: begin
            offset_sel = OFFSET_SIXTEEN;
            max_sel    = MAX_SIXTEEN;
         end
         default: begin
            offset_sel = OFFSET_FOUR;
            max_sel    = MAX_FOUR;
         end
      endcase
   end

   assign offset_sum = {floor_q[24], floor_q} + $signed({9'b0, offset_sel});

   always_comb begin
      if (offset_sum < 0) begin
         wide_code = 16'd0;
      end else if (offset_sum > $signed({9'b0, max_sel})) begin
         wide_code = max_sel[15:0];
      end else begin
         wide_code = offset_sum[15:0];
      end
   end

   always_comb begin
      unique case (mode_ff) inside
         MODE_ONE: begin
            narrow_code = {3'b0, !s1_sign_ff};
            width_w     = 4'd1;
         end
         MODE_TWO: begin
            narrow_code = {2'b0, s1_code2_ff};
            width_w     = 4'd2;
         end
         default: begin
            narrow_code = wide_code[3:0];
            width_w     = 4'd4;
         end
      endcase
   end

   assign shifted = {8'b0, narrow_code} << pos_ff;
   assign acc_or  = acc_ff | shifted[7:0];
   assign pos_sum = {1'b0, pos_ff} + width_w;

   always_comb begin
      acc_in  = acc_ff;
      pos_in  = pos_ff;
      emit    = 1'b0;
      entry_c = '{byte_lo: 8'd0, byte_hi: 8'd0, two_bytes: 1'b0,
                  frame_end: s1_eof_ff};
      unique case (mode_ff) inside
         MODE_ONE, MODE_TWO, MODE_FOUR: begin
            if (pos_sum >= 4'd8) begin
               emit          = 1'b1;
               entry_c.byte_lo = acc_or;
               acc_in        = 8'd0;
               pos_in        = 3'd0;
            end else begin
               acc_in = acc_or;
               pos_in = pos_sum[2:0];
            end
         end
         MODE_EIGHT: begin
            emit            = 1'b1;
            entry_c.byte_lo = wide_code[7:0];
            acc_in          = 8'd0;
            pos_in          = 3'd0;
         end
         MODE_SIXTEEN: begin
            emit              = 1'b1;
            entry_c.byte_lo   = wide_code[7:0];
            entry_c.byte_hi   = wide_code[15:8];
            entry_c.two_bytes = 1'b1;
            acc_in            = 8'd0;
            pos_in            = 3'd0;
         end
         default: begin
            // reserved widths leave packing alone, but an end of frame still clears it
            emit = 1'b0;
         end
      endcase
      if (s1_eof_ff) begin
         acc_in = 8'd0;
         pos_in = 3'd0;
      end
   end

   assign push       = s1_valid_ff && emit;
   assign push_entry = entry_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= RST_BITS_MODE;
         thresh_ff   <= RST_THRESHOLD;
         gain48_ff   <= RST_GAIN_48;
         gain16_ff   <= RST_GAIN_16;
         acc_ff      <= 8'd0;
         pos_ff      <= 3'd0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_BITS_MODE: mode_ff   <= csr_write_data[2:0];
               CSR_THRESHOLD: thresh_ff <= csr_write_data;
               CSR_GAIN_48:   gain48_ff <= csr_write_data;
               CSR_GAIN_16:   gain16_ff <= csr_write_data;
               default:       mode_ff   <= mode_ff;
            endcase
         end
         s1_valid_ff <= accept;
         if (s1_valid_ff) begin
            acc_ff <= acc_in;
            pos_ff <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_product_ff <= product_c;
         s1_code2_ff   <= code2_c;
         s1_sign_ff    <= req_sample[SAMPLE_W-1];
         s1_eof_ff     <= req_end_of_frame;
      end
   end

endmodule

>>> rtl/core/sqbp_queue.sv
module sqbp_queue import sqbp_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  sqbp_entry_type push_entry,
   input  logic           pop,
   output sqbp_entry_type head,
   output sqbp_qstat_type qstat
);

`include "sample_quantizer_bit_packer_assert.svh"

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sqbp_entry_type   mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign head            = mem_ff[rd_ptr_ff];
   assign qstat.empty     = (count_ff == '0);
   assign qstat.full      = (count_ff >= CNT_W'(DEPTH));
   assign qstat.near_full = (count_ff >= CNT_W'(DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `SQBP_ASSERT_IMPLY(a_no_push_when_full, push, !qstat.full || pop, "queue overrun")
   `SQBP_ASSERT_IMPLY(a_no_pop_when_empty, pop, !qstat.empty, "queue underrun")
   `SQBP_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(DEPTH), "queue count out of range")

endmodule

>>> rtl/core/sqbp_back.sv
module sqbp_back import sqbp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  sqbp_entry_type head,
   input  sqbp_qstat_type qstat,
   output logic           pop,
   output logic           rsp_empty,
   input  logic           rsp_pop,
   output logic [7:0]     rsp_packed_byte,
   output logic           rsp_last_of_item,
   output logic           rsp_frame_end
);

`include "sample_quantizer_bit_packer_assert.svh"

   logic       out_valid_ff;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;
   logic       out_frame_ff;
   logic       hi_pending_ff;
   logic [7:0] hi_byte_ff;
   logic       hi_frame_ff;
   logic       load;

   // output slot frees when empty or when its beat is taken
   assign load = !out_valid_ff || rsp_pop;
   assign pop  = load && !hi_pending_ff && !qstat.empty;

   assign rsp_empty        = !out_valid_ff;
   assign rsp_packed_byte  = out_byte_ff;
   assign rsp_last_of_item = out_last_ff;
   assign rsp_frame_end    = out_frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hi_pending_ff <= 1'b0;
      end else if (load) begin
         if (hi_pending_ff) begin
            out_valid_ff  <= 1'b1;
            hi_pending_ff <= 1'b0;
         end else if (!qstat.empty) begin
            out_valid_ff  <= 1'b1;
            hi_pending_ff <= head.two_bytes;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (hi_pending_ff) begin
            out_byte_ff  <= hi_byte_ff;
            out_last_ff  <= 1'b1;
            out_frame_ff <= hi_frame_ff;
         end else if (!qstat.empty) begin
            out_byte_ff  <= head.byte_lo;
            out_last_ff  <= !head.two_bytes;
            out_frame_ff <= !head.two_bytes && head.frame_end;
            hi_byte_ff   <= head.byte_hi;
            hi_frame_ff  <= head.frame_end;
         end
      end
   end

   `SQBP_ASSERT_IMPLY(a_hi_needs_lo, hi_pending_ff, out_valid_ff, "high byte without low byte")
   `SQBP_ASSERT_IMPLY(a_not_last_has_hi, out_valid_ff && !out_last_ff, hi_pending_ff,
      "first byte shown with no second byte waiting")
   `SQBP_ASSERT_IMPLY(a_frame_on_last, out_valid_ff && out_frame_ff, out_last_ff,
      "frame end on a byte that is not last")

endmodule

>>> rtl/core/sample_quantizer_bit_packer.sv
// Quantizes one signed Q16.16 sample per beat to 1, 2, 4, 8 or 16 bits and packs the codes
// least significant first into bytes; 16-bit codes leave as two bytes, low byte first. A
// sample is taken every cycle while full is low; its first byte reaches the rsp_ ports via
// the multiply register, the queue and the output register. The output port moves one byte
// per cycle while pop is high, so 16-bit mode, with two bytes per sample, raises full to
// hold the input back; a queue of QUEUE_DEPTH byte groups between quantizer and output lets
// either side stall without stopping the other. The user must write configuration through
// the csr_ port only while no sample is in flight; the block itself does not enforce it.
module sample_quantizer_bit_packer import sqbp_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       full,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_end_of_frame,
   output logic                       empty,
   input  logic                       pop,
   output logic [7:0]                 rsp_packed_byte,
   output logic                       rsp_last_of_item,
   output logic                       rsp_frame_end,
   input  logic                       csr_write_enable,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]           csr_write_data
);

   sqbp_qstat_type qstat;
   sqbp_entry_type push_entry;
   sqbp_entry_type head;
   logic           q_push;
   logic           q_pop;

   sqbp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (full),
      .req_sample       (req_sample),
      .req_end_of_frame (req_end_of_frame),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .qstat            (qstat),
      .push             (q_push),
      .push_entry       (push_entry)
   );

   sqbp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head),
      .qstat      (qstat)
   );

   sqbp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .qstat            (qstat),
      .pop              (q_pop),
      .rsp_empty        (empty),
      .rsp_pop          (pop),
      .rsp_packed_byte  (rsp_packed_byte),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_frame_end    (rsp_frame_end)
   );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import sqbp_pkg::*;

   // bits_mode values with no defined width
   localparam logic [2:0] MODE_SPARE_A = 3'd5;
   localparam logic [2:0] MODE_SPARE_B = 3'd6;
   localparam logic [2:0] MODE_SPARE_C = 3'd7;

   localparam int TARGET_SAMPLES  = 700;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 20;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int IDLE_PCT        = 27;

   typedef struct packed {
      logic [2:0]                 mode;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       eof;
      logic                       typed;
      logic [15:0]                code;
   } directed_row_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       eof;
      logic                       typed;
      logic [15:0]                code;
   } sample_beat_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       frame_end;
   } packed_byte_type;

   logic                       clock;
   logic                       reset;
   logic                       req_push;
   logic                       full;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       req_end_of_frame;
   logic                       empty;
   logic                       pop;
   logic [7:0]                 rsp_packed_byte;
   logic                       rsp_last_of_item;
   logic                       rsp_frame_end;
   logic                       csr_write_enable;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_W-1:0]           csr_write_data;

   // register and packing state as the block should hold them
   logic [2:0]       cfg_mode      = RST_BITS_MODE;
   logic [CSR_W-1:0] cfg_threshold = RST_THRESHOLD;
   logic [CSR_W-1:0] cfg_gain_48   = RST_GAIN_48;
   logic [CSR_W-1:0] cfg_gain_16   = RST_GAIN_16;
   logic [7:0]       acc_byte      = '0;
   logic [2:0]       acc_pos       = '0;

   packed_byte_type bytes_due [$];
   sample_beat_type offered;
   int              errors      = 0;
   int              cycles      = 0;
   int              hold_left   = 0;
   bit              steady      = 1'b0;
   bit              stall_armed = 1'b0;

   sample_quantizer_bit_packer dut (
      .clock,
      .reset,
      .req_push,
      .full,
      .req_sample,
      .req_end_of_frame,
      .empty,
      .pop,
      .rsp_packed_byte,
      .rsp_last_of_item,
      .rsp_frame_end,
      .csr_write_enable,
      .csr_index,
      .csr_write_data
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      errors++;
      $display("[%0t] %s mismatch: got 'h%0h, expected 'h%0h", $time, what, got, want);
   endtask

   // floor(sample * gain / 2^32)
   function automatic longint floor_product(input logic signed [SAMPLE_W-1:0] s,
                                            input logic [CSR_W-1:0] gain);
      longint prod;
      prod = longint'(s) * longint'({40'd0, gain});
      return prod >>> 32;
   endfunction

   function automatic logic [15:0] saturate_code(input longint level, input logic [16:0] offset,
                                                 input logic [16:0] ceiling);
      longint q;
      q = level + longint'({47'd0, offset});
      if (q < 0)
         q = 0;
      if (q > longint'({47'd0, ceiling}))
         q = longint'({47'd0, ceiling});
      return q[15:0];
   endfunction

   // returns the number of bytes the sample completes, updates packing state
   function automatic int quantize_and_pack(input sample_beat_type beat, output logic [7:0] lo,
                                            output logic [7:0] hi);
      logic signed [SAMPLE_W-1:0] s;
      longint                     sv;
      longint                     th;
      logic [3:0]                 code;
      logic [15:0]                wide;
      logic [11:0]                shifted;
      int                         width;
      int                         count;
      s     = beat.sample;
      sv    = longint'(s);
      th    = longint'({40'd0, cfg_threshold});
      lo    = '0;
      hi    = '0;
      code  = '0;
      width = 0;
      count = 0;
      case (cfg_mode)
         MODE_ONE: begin
            width = 1;
            code  = (sv < 0) ? 4'd0 : 4'd1;
         end
         MODE_TWO: begin
            width = 2;
            if (sv < -th)
               code = 4'd0;
            else if (sv < 0)
               code = 4'd1;
            else if (sv < th)
               code = 4'd2;
            else
               code = 4'd3;
         end
         MODE_FOUR: begin
            width = 4;
            wide  = saturate_code(floor_product(s, cfg_gain_48), OFFSET_FOUR, MAX_FOUR);
            code  = wide[3:0];
         end
         MODE_EIGHT: begin
            wide     = saturate_code(floor_product(s, cfg_gain_48), OFFSET_EIGHT, MAX_EIGHT);
            acc_byte = '0;
            acc_pos  = '0;
            lo       = wide[7:0];
            count    = 1;
         end
         MODE_SIXTEEN: begin
            wide     = saturate_code(floor_product(s, cfg_gain_16), OFFSET_SIXTEEN, MAX_SIXTEEN);
            acc_byte = '0;
            acc_pos  = '0;
            lo       = wide[7:0];
            hi       = wide[15:8];
            count    = 2;
         end
         default: ;
      endcase
      if (width > 0) begin
         // bits pushed past bit 7 are simply lost
         shifted  = {8'd0, code} << acc_pos;
         acc_byte = acc_byte | shifted[7:0];
         if (int'(acc_pos) + width >= 8) begin
            lo       = acc_byte;
            count    = 1;
            acc_byte = '0;
            acc_pos  = '0;
         end else begin
            acc_pos = acc_pos + 3'(width);
         end
      end
      if (beat.eof) begin
         acc_byte = '0;
         acc_pos  = '0;
      end
      return count;
   endfunction

   always @(posedge clock) begin : byte_check
      logic [7:0]      lo_byte;
      logic [7:0]      hi_byte;
      int              produced;
      packed_byte_type want;
      if (!reset) begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BITS_MODE: cfg_mode      = csr_write_data[2:0];
               CSR_THRESHOLD: cfg_threshold = csr_write_data;
               CSR_GAIN_48:   cfg_gain_48   = csr_write_data;
               CSR_GAIN_16:   cfg_gain_16   = csr_write_data;
               default: ;
            endcase
         end
         if (req_push && !full) begin
            produced = quantize_and_pack(offered, lo_byte, hi_byte);
            if (offered.typed) begin
               lo_byte = offered.code[7:0];
               hi_byte = offered.code[15:8];
            end
            if (produced == 1) begin
               bytes_due.push_back(packed_byte_type'{lo_byte, 1'b1, offered.eof});
            end else if (produced == 2) begin
               bytes_due.push_back(packed_byte_type'{lo_byte, 1'b0, 1'b0});
               bytes_due.push_back(packed_byte_type'{hi_byte, 1'b1, offered.eof});
            end
         end
         if (pop && !empty) begin
            if (bytes_due.size() == 0) begin
               report_mismatch("unexpected byte", rsp_packed_byte, -1);
            end else begin
               want = bytes_due.pop_front();
               if (rsp_packed_byte != want.data)
                  report_mismatch("packed_byte", rsp_packed_byte, want.data);
               if (rsp_last_of_item != want.last)
                  report_mismatch("last_of_item", rsp_last_of_item, want.last);
               if (rsp_frame_end != want.frame_end)
                  report_mismatch("frame_end", rsp_frame_end, want.frame_end);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("sample_quantizer_bit_packer verification failed");
         $finish;
      end
   end

   // output side: random pop, one long hold-off when armed
   initial begin
      pop = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (stall_armed) begin
            stall_armed = 1'b0;
            hold_left   = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic send_sample(input sample_beat_type beat);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push         <= 1'b1;
      req_sample       <= beat.sample;
      req_end_of_frame <= beat.eof;
      offered          <= beat;
      @(posedge clock);
      while (full)
         @(posedge clock);
      @(negedge clock);
   endtask

   // waits for the block to drain, then writes the mode and optionally the rest
   task automatic configure(input logic [2:0] mode, input logic [CSR_W-1:0] th,
                            input logic [CSR_W-1:0] g48, input logic [CSR_W-1:0] g16,
                            input bit mode_only);
      req_push <= 1'b0;
      while (bytes_due.size() != 0)
         @(negedge clock);
      // a trailing partial byte leaves nothing due but may still be in the pipe
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_BITS_MODE;
      csr_write_data   <= {21'd0, mode};
      @(negedge clock);
      if (!mode_only) begin
         csr_index      <= CSR_THRESHOLD;
         csr_write_data <= th;
         @(negedge clock);
         csr_index      <= CSR_GAIN_48;
         csr_write_data <= g48;
         @(negedge clock);
         csr_index      <= CSR_GAIN_16;
         csr_write_data <= g16;
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [CSR_W-1:0] random_level(input logic [CSR_W-1:0] nominal);
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         2:       return nominal;
         3:       return CSR_W'($urandom_range(1, 1 << 20));
         default: return CSR_W'($urandom());
      endcase
   endfunction

   function automatic sample_beat_type random_beat();
      sample_beat_type b;
      longint          v;
      case ($urandom_range(0, 9))
         0: v = longint'($signed($urandom()));
         1: begin
            case ($urandom_range(0, 4))
               0:       v = -64'sd2147483648;
               1:       v = 64'sd2147483647;
               2:       v = -64'sd1;
               3:       v = 64'sd0;
               default: v = 64'sd1;
            endcase
         end
         2: begin
            // right at the 2-bit split points
            v = longint'({40'd0, cfg_threshold}) + longint'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1) == 1)
               v = -v;
         end
         3:       v = longint'($urandom_range(0, 2048)) - 1024;
         default: v = longint'($urandom_range(0, 262144)) - 131072;
      endcase
      b.sample = v[SAMPLE_W-1:0];
      b.eof    = ($urandom_range(0, 11) == 0);
      b.typed  = 1'b0;
      b.code   = '0;
      return b;
   endfunction

   initial begin
      directed_row_type rows [0:25];
      sample_beat_type  beat;
      logic [2:0]       mode_now;
      logic [2:0]       mode;
      logic [CSR_W-1:0] th;
      logic [CSR_W-1:0] g48;
      logic [CSR_W-1:0] g16;
      int               pick;
      int               real_items;
      int               n_items;
      int               phase;

      rows = '{
         '{MODE_EIGHT,   32'sh80000000, 1'b0, 1'b1, 16'd0},
         '{MODE_EIGHT,   32'sh7FFFFFFF, 1'b0, 1'b1, 16'd255},
         '{MODE_EIGHT,   32'sd0,        1'b0, 1'b1, 16'd128},
         '{MODE_SIXTEEN, 32'sh7FFFFFFF, 1'b0, 1'b1, 16'hFFFF},
         '{MODE_SIXTEEN, 32'sh80000000, 1'b0, 1'b1, 16'h0000},
         '{MODE_SIXTEEN, 32'sd0,        1'b1, 1'b1, 16'h8000},
         '{MODE_FOUR,    32'sh80000000, 1'b0, 1'b0, 16'd0},
         '{MODE_FOUR,    32'sh7FFFFFFF, 1'b0, 1'b0, 16'd0},
         '{MODE_FOUR,    -32'sd1,       1'b0, 1'b0, 16'd0},
         '{MODE_FOUR,    32'sd0,        1'b0, 1'b0, 16'd0},
         '{MODE_TWO,     -32'sd62916,   1'b0, 1'b0, 16'd0},
         '{MODE_TWO,     -32'sd62915,   1'b0, 1'b0, 16'd0},
         '{MODE_TWO,     -32'sd1,       1'b0, 1'b0, 16'd0},
         '{MODE_TWO,     32'sd62914,    1'b0, 1'b0, 16'd0},
         '{MODE_TWO,     32'sd62915,    1'b0, 1'b0, 16'd0},
         '{MODE_TWO,     32'sd0,        1'b1, 1'b0, 16'd0},
         '{MODE_ONE,     -32'sd1,       1'b0, 1'b0, 16'd0},
         '{MODE_ONE,     32'sd0,        1'b0, 1'b0, 16'd0},
         '{MODE_ONE,     32'sh80000000, 1'b0, 1'b0, 16'd0},
         '{MODE_ONE,     32'sh7FFFFFFF, 1'b1, 1'b0, 16'd0},
         '{MODE_TWO,     32'sd62915,    1'b0, 1'b0, 16'd0},
         '{MODE_TWO,     32'sd62915,    1'b0, 1'b0, 16'd0},
         '{MODE_TWO,     32'sd62915,    1'b0, 1'b0, 16'd0},
         '{MODE_SPARE_B, 32'sd0,        1'b0, 1'b0, 16'd0},
         '{MODE_FOUR,    32'sh7FFFFFFF, 1'b0, 1'b0, 16'd0},
         '{MODE_SPARE_C, 32'sd5,        1'b1, 1'b0, 16'd0}
      };

      reset            = 1'b1;
      req_push         = 1'b0;
      req_sample       = '0;
      req_end_of_frame = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_BITS_MODE;
      csr_write_data   = '0;
      offered          = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows; a mode change mid-byte keeps the partial byte
      mode_now = RST_BITS_MODE;
      foreach (rows[i]) begin
         if (rows[i].mode != mode_now) begin
            configure(rows[i].mode, cfg_threshold, cfg_gain_48, cfg_gain_16, 1'b1);
            mode_now = rows[i].mode;
         end
         beat = '{rows[i].sample, rows[i].eof, rows[i].typed, rows[i].code};
         send_sample(beat);
      end

      phase      = 0;
      real_items = 0;
      while (real_items < TARGET_SAMPLES) begin
         pick = $urandom_range(0, 10);
         mode = (pick < 10) ? 3'(pick % 5) : MODE_SPARE_A + 3'($urandom_range(0, 2));
         th   = random_level(RST_THRESHOLD);
         g48  = random_level(RST_GAIN_48);
         g16  = random_level(RST_GAIN_16);
         if (phase == 0) begin
            th  = '0;
            g48 = '0;
            g16 = '0;
         end else if (phase == 1) begin
            th  = '1;
            g48 = '1;
            g16 = '1;
         end else if (phase == 2) begin
            mode = MODE_SIXTEEN;
         end else if (phase == 4) begin
            mode = 3'($urandom_range(0, 4));
         end
         configure(mode, th, g48, g16, 1'b0);
         steady = (phase == 4);
         // long output stall while input keeps coming
         if (phase == 2)
            stall_armed = 1'b1;
         n_items = (mode > MODE_SIXTEEN) ? 8 : $urandom_range(40, 80);
         repeat (n_items) send_sample(random_beat());
         if (mode <= MODE_SIXTEEN)
            real_items += n_items;
         phase++;
      end
      steady = 1'b0;

      req_push <= 1'b0;
      while (bytes_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0)
         $display("sample_quantizer_bit_packer verification clean");
      else
         $display("sample_quantizer_bit_packer verification failed");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/sqbp_pkg.sv
rtl/core/sqbp_front.sv
rtl/core/sqbp_queue.sv
rtl/core/sqbp_back.sv
rtl/core/sample_quantizer_bit_packer.sv
test/tb_top.sv
